@@ rtl/core/tfn_pkg.sv @@
// tfn_pkg: shared constants and types of the triangle face normal block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

  localparam int COORD_BITS_DEF       = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;

  // depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } tfn_q_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/tfn_in_if.sv @@
// tfn_in_if: triangle channel, valid/ready with the three vertices
// depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tfn_in_if
  import tfn_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_z;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] second_z;
  logic signed [COORD_BITS-1:0] third_x;
  logic signed [COORD_BITS-1:0] third_y;
  logic signed [COORD_BITS-1:0] third_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    input  ready
  );

  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/core/tfn_out_if.sv @@
// tfn_out_if: normal channel, valid/ready with the unit normal and flag
// depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tfn_out_if
  import tfn_pkg::*;
#(
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) ();

  logic                                valid;
  logic                                ready;
  logic signed [NORMAL_FRAC_BITS+1:0]  normal_x;
  logic signed [NORMAL_FRAC_BITS+1:0]  normal_y;
  logic signed [NORMAL_FRAC_BITS+1:0]  normal_z;
  logic                                degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );

  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );

endinterface

`default_nettype wire

@@ rtl/core/tfn_fifo.sv @@
// tfn_fifo: short register queue between the front and back parts
// depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfn_fifo
  import tfn_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output tfn_q_stat_t      stat
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CW'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tfn_front.sv @@
// tfn_front: takes triangles, forms edges and the exact cross product,
// flags zero cross products; depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfn_front
  import tfn_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_BITS-1:0]    vtx [9],
  input  tfn_q_stat_t                     q_stat,
  output logic                            push,
  output logic [3*(2*COORD_BITS+3):0]     push_data
);

  localparam int E  = COORD_BITS + 1;
  localparam int NW = 2 * COORD_BITS + 3;

  logic                 v1_r, v2_r, v3_r;
  logic                 en;
  logic signed [E-1:0]    e_r [6];
  logic signed [2*E-1:0]  p_r [6];
  logic signed [NW-1:0]   n_r [3];
  logic                   dg_r;

  assign en        = !v3_r || !q_stat.full;
  assign in_ready  = en;
  assign push      = v3_r && !q_stat.full;
  assign push_data = {dg_r, n_r[2], n_r[1], n_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_r[i]   <= $signed({vtx[3+i][COORD_BITS-1], vtx[3+i]})
                  - $signed({vtx[i][COORD_BITS-1], vtx[i]});
        e_r[3+i] <= $signed({vtx[6+i][COORD_BITS-1], vtx[6+i]})
                  - $signed({vtx[i][COORD_BITS-1], vtx[i]});
      end
      // u = e[0..2], v = e[3..5]
      p_r[0] <= e_r[1] * e_r[5];
      p_r[1] <= e_r[2] * e_r[4];
      p_r[2] <= e_r[2] * e_r[3];
      p_r[3] <= e_r[0] * e_r[5];
      p_r[4] <= e_r[0] * e_r[4];
      p_r[5] <= e_r[1] * e_r[3];
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= NW'(p_r[2*i]) - NW'(p_r[2*i+1]);
      end
      dg_r <= (p_r[0] == p_r[1]) && (p_r[2] == p_r[3]) && (p_r[4] == p_r[5]);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tfn_back.sv @@
// tfn_back: squared length and bit-per-stage rounded scaling of each
// cross component to a unit normal; depends on tfn_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfn_back
  import tfn_pkg::*;
#(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tfn_q_stat_t                        q_stat,
  input  logic [3*(2*COORD_BITS+3):0]        pop_data,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_z,
  output logic                               out_degenerate
);

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NW  = 2 * COORD_BITS + 3;
  localparam int AW  = 2 * COORD_BITS + 2;
  localparam int H   = COORD_BITS + 1;
  localparam int LW  = 4 * COORD_BITS + 4;
  localparam int RW  = 4 * COORD_BITS + 2 * F + 10;
  localparam int QW  = F + 1;
  localparam int OW  = F + 2;
  localparam int NS  = F + 1;
  localparam int NST = NS + 5;

  logic en_b;

  logic           vb_r [NST];
  logic [2:0]     ng_r [NST];
  logic           dg_r [NST];

  logic [AW-1:0]    a_r   [3];
  logic [2*H-1:0]   hh_r  [3];
  logic [2*H-1:0]   hl_r  [3];
  logic [2*H-1:0]   ll_r  [3];
  logic [LW-1:0]    sq_r  [3];
  logic [LW-1:0]    sqd_r [3];
  logic [LW-1:0]    len_r;
  logic signed [RW-1:0] r_r [NS][3];
  logic signed [RW-1:0] p_r [NS][3];
  logic [LW-1:0]        l_r [NS];
  logic [QW-1:0]        q_r [NS+1][3];

  logic                         out_valid_r;
  logic signed [OW-1:0]         nrm_r [3];
  logic                         odg_r;

  logic signed [NW-1:0] n_in [3];
  logic [2:0]           neg_in;

  assign en_b = !out_valid_r || out_ready;
  assign pop  = en_b && !q_stat.empty;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_in[i]   = $signed(pop_data[i*NW +: NW]);
      neg_in[i] = n_in[i][NW-1];
    end
  end

  // valid, sign and degenerate flag travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NST; j++) begin
        vb_r[j] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en_b) begin
      vb_r[0] <= !q_stat.empty;
      for (int j = 1; j < NST; j++) begin
        vb_r[j] <= vb_r[j-1];
      end
      out_valid_r <= vb_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      ng_r[0] <= neg_in;
      dg_r[0] <= pop_data[3*NW];
      for (int j = 1; j < NST; j++) begin
        ng_r[j] <= ng_r[j-1];
        dg_r[j] <= dg_r[j-1];
      end
      for (int i = 0; i < 3; i++) begin
        a_r[i]  <= neg_in[i] ? AW'(-n_in[i]) : AW'(n_in[i]);
        hh_r[i] <= a_r[i][AW-1:H] * a_r[i][AW-1:H];
        hl_r[i] <= a_r[i][AW-1:H] * a_r[i][H-1:0];
        ll_r[i] <= a_r[i][H-1:0] * a_r[i][H-1:0];
        sq_r[i] <= (LW'(hh_r[i]) << (2 * H)) + (LW'(hl_r[i]) << (H + 1))
                 + LW'(ll_r[i]);
        sqd_r[i] <= sq_r[i];
      end
      len_r <= sq_r[0] + sq_r[1] + sq_r[2];
      // residue T - L and running (2q-1)L with q = 0
      l_r[0] <= len_r;
      for (int i = 0; i < 3; i++) begin
        r_r[0][i] <= ($signed(RW'(sqd_r[i])) <<< (2 * F + 2))
                   - $signed(RW'(len_r));
        p_r[0][i] <= -$signed(RW'(len_r));
        q_r[0][i] <= '0;
      end
    end
  end

  // one quotient bit per stage, msb first
  for (genvar g = 0; g < NS; g++) begin : g_dig
    localparam int K = F - g;
    logic signed [RW-1:0] lg;
    logic signed [RW-1:0] rn  [3];
    logic [2:0]           acc;

    assign lg = $signed(RW'(l_r[g]));

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rn[i]  = r_r[g][i] - ((p_r[g][i] <<< (K + 2)) + (lg <<< (2 * K + 2)));
        acc[i] = !rn[i][RW-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en_b) begin
        for (int i = 0; i < 3; i++) begin
          q_r[g+1][i] <= q_r[g][i] | (QW'(acc[i]) << K);
        end
      end
    end

    if (g < NS - 1) begin : g_upd
      always_ff @(posedge clk) begin
        if (en_b) begin
          l_r[g+1] <= l_r[g];
          for (int i = 0; i < 3; i++) begin
            r_r[g+1][i] <= acc[i] ? rn[i] : r_r[g][i];
            p_r[g+1][i] <= acc[i] ? p_r[g][i] + (lg <<< (K + 1)) : p_r[g][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      odg_r <= dg_r[NST-1];
      for (int i = 0; i < 3; i++) begin
        if (dg_r[NST-1]) begin
          nrm_r[i] <= '0;
        end else if (ng_r[NST-1][i]) begin
          nrm_r[i] <= -$signed({1'b0, q_r[NS][i]});
        end else begin
          nrm_r[i] <= $signed({1'b0, q_r[NS][i]});
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_degenerate = odg_r;

endmodule

`default_nettype wire

@@ rtl/core/triangle_face_normal.sv @@
// triangle_face_normal: unit face normal of a triangle in signed fixed point
// throughput: one triangle per cycle unless out_ready stalls, set by the pipelined
//   edge/cross front, a two-beat queue, and one stage per quotient bit in the back
// reset: synchronous active-low rst_n clears all valid and queue state
// depends on tfn_pkg, tfn_in_if, tfn_out_if, tfn_fifo, tfn_front, tfn_back
`timescale 1ns / 1ps
`default_nettype none

module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  tfn_in_if.sink   in_if,
  tfn_out_if.source out_if
);

  localparam int QDW = 3 * (2 * COORD_BITS + 3) + 1;
  localparam int ONE = 1 << NORMAL_FRAC_BITS;

  logic signed [COORD_BITS-1:0] vtx [9];
  logic                         push;
  logic                         pop;
  logic [QDW-1:0]               push_data;
  logic [QDW-1:0]               pop_data;
  tfn_q_stat_t                  q_stat;

  assign vtx[0] = in_if.first_x;
  assign vtx[1] = in_if.first_y;
  assign vtx[2] = in_if.first_z;
  assign vtx[3] = in_if.second_x;
  assign vtx[4] = in_if.second_y;
  assign vtx[5] = in_if.second_z;
  assign vtx[6] = in_if.third_x;
  assign vtx[7] = in_if.third_y;
  assign vtx[8] = in_if.third_z;

  tfn_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .vtx      (vtx),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  tfn_fifo #(
    .WIDTH(QDW)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .stat     (q_stat)
  );

  tfn_back #(
    .COORD_BITS      (COORD_BITS),
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_normal_x  (out_if.normal_x),
    .out_normal_y  (out_if.normal_y),
    .out_normal_z  (out_if.normal_z),
    .out_degenerate(out_if.degenerate)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push || pop)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.degenerate |->
      out_if.normal_x == '0 && out_if.normal_y == '0 && out_if.normal_z == '0)
    else $error("degenerate beat with nonzero normal");

  a_nondegen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.degenerate |->
      out_if.normal_x != '0 || out_if.normal_y != '0 || out_if.normal_z != '0)
    else $error("zero normal without degenerate flag");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |->
      out_if.normal_x <= ONE && out_if.normal_x >= -ONE &&
      out_if.normal_y <= ONE && out_if.normal_y >= -ONE &&
      out_if.normal_z <= ONE && out_if.normal_z >= -ONE)
    else $error("normal component out of unit range");

endmodule

`default_nettype wire
